// ===== rtl/rd_pkg.sv =====
package rd_pkg;

  // Default number of stored elements.
  localparam int unsigned DepthDef = 16;

  // Fixed field widths of the item and result formats.
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_PUSH_HEAD = 2'd0,
    OP_PUSH_TAIL = 2'd1,
    OP_POP_HEAD  = 2'd2,
    OP_REVERSE   = 2'd3
  } rd_op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } rd_status_e;

  typedef struct packed {
    rd_op_e                    operation;
    logic signed [DataW-1:0]   value;
  } rd_in_t;

  typedef struct packed {
    rd_status_e                status;
    logic signed [DataW-1:0]   removed_value;
    logic [CountW-1:0]         count;
  } rd_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the accepted item
    logic exec;     // apply the operation to the ring state
    logic capture;  // load the result register
  } rd_cmd_t;

endpackage

// ===== rtl/rd_ctrl.sv =====
module rd_ctrl
  import rd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output rd_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Sequence one item through load, execute and result capture.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_RESULT;
      end
      S_RESULT: begin
        // The result register is free when empty or being drained this cycle.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // A result stays valid until its transfer completes.
  always_comb begin
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/rd_datapath.sv =====
module rd_datapath
  import rd_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  rd_cmd_t cmd_i,
  input  rd_in_t  in_data_i,
  output rd_out_t out_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);
  localparam logic [SumW-1:0] SumDepth = SumW'(DEPTH);

  // Accepted item.
  rd_op_e               op_q;
  logic [DataW-1:0]     value_q;

  // Ring state.
  logic [PtrW-1:0]      front_q, front_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 rev_q, rev_d;

  // Per-item results waiting for capture.
  rd_status_e           status_q, status_d;
  logic                 pop_ok_q, pop_ok_d;

  // Element store with registered read.
  logic [DataW-1:0]     mem_q [DEPTH];
  logic [DataW-1:0]     rdata_q;
  logic                 wr_en;
  logic [PtrW-1:0]      wr_addr;
  logic [PtrW-1:0]      rd_addr;

  rd_out_t              out_q;

  logic [PtrW-1:0]      front_dec;
  logic [PtrW-1:0]      front_inc;
  logic [SumW-1:0]      high_sum;
  logic [SumW-1:0]      high_last;
  logic [PtrW-1:0]      high_free_idx;
  logic [PtrW-1:0]      high_last_idx;
  logic                 full;
  logic                 empty;
  logic                 go_low;
  logic [CntW+CountW-1:0] cnt_wide;

  // Ring pointer arithmetic, each index wrapped into range with a single compare.
  assign front_dec = (front_q == '0) ? PtrLast : front_q - PtrW'(1);
  assign front_inc = (front_q == PtrLast) ? '0 : front_q + PtrW'(1);
  assign high_sum  = SumW'(front_q) + SumW'(cnt_q);
  assign high_last = high_sum - SumW'(1);
  assign high_free_idx = (high_sum >= SumDepth) ? PtrW'(high_sum - SumDepth)
                                                : PtrW'(high_sum);
  assign high_last_idx = (high_last >= SumDepth) ? PtrW'(high_last - SumDepth)
                                                 : PtrW'(high_last);

  assign full   = (cnt_q == CntFull);
  assign empty  = (cnt_q == '0);
  assign go_low = (op_q == OP_PUSH_HEAD) ? !rev_q : rev_q;

  // Decode the operation into the next ring state and store accesses.
  always_comb begin
    front_d  = front_q;
    cnt_d    = cnt_q;
    rev_d    = rev_q;
    status_d = ST_OK;
    pop_ok_d = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = high_free_idx;
    rd_addr  = rev_q ? high_last_idx : front_q;
    case (op_q)
      OP_PUSH_HEAD, OP_PUSH_TAIL: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + CntW'(1);
          if (go_low) begin
            front_d = front_dec;
            wr_addr = front_dec;
          end
        end
      end
      OP_POP_HEAD: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          pop_ok_d = 1'b1;
          cnt_d    = cnt_q - CntW'(1);
          if (!rev_q) begin
            front_d = front_inc;
          end
        end
      end
      OP_REVERSE: begin
        rev_d = !rev_q;
      end
      default: begin
        rev_d = rev_q;
      end
    endcase
  end

  // Control state of the ring.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      cnt_q   <= '0;
      rev_q   <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      cnt_q   <= cnt_d;
      rev_q   <= rev_d;
    end
  end

  // Item and per-item result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_data_i.operation;
      value_q <= in_data_i.value;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  // Element store: at most one write and one registered read per execute cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem_q[wr_addr] <= value_q;
    end
    if (cmd_i.exec) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // The reported count is the low bits of the occupancy.
  assign cnt_wide = {{CountW{1'b0}}, cnt_q};

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      out_q.status        <= status_q;
      out_q.removed_value <= pop_ok_q ? rdata_q : '0;
      out_q.count         <= cnt_wide[CountW-1:0];
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/reversible_deque.sv =====
// A result passes the item register, the execute step with its registered
// store read and the result register; a new item is taken only once the
// controller has left its capture step and returned to idle.
// A stalled result holds the controller in its capture step, so the input
// stays stalled until the result register can take the new result.
// Reset clears the pointer, count, direction flag and result valid; the
// element store holds no defined values until written.
module reversible_deque
  import rd_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  rd_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output rd_out_t out_data_o
);

  rd_cmd_t cmd;

  rd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  rd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/rd_checker.sv =====
module rd_checker
  import rd_pkg::*;
#(
  parameter int unsigned Depth = DepthDef
) (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_stall_o,
  input logic    out_valid_o,
  input logic    out_stall_i,
  input rd_out_t out_data_o
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // One item at a time: the input stalls right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // A refused operation never reports a removed value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.removed_value == '0)
    else $error("refused operation carries a value");

  // A refused remove means the queue is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_EMPTY) |-> out_data_o.count == '0)
    else $error("empty status with nonzero count");

  // The occupancy never exceeds the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (Depth > 31) || (32'(out_data_o.count) <= Depth))
    else $error("count above depth");

endmodule

bind reversible_deque rd_checker #(
  .Depth (DEPTH)
) u_rd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
